@@ hw/rtl/tpa_pkg.sv @@
// ============================================================================
// tpa_pkg - shared constants for the trapezoid position advance block
// Register map and fixed format constants.
// ============================================================================
package tpa_pkg;

    // Integer bits of the unsigned time step format
    localparam int STEP_INT_BITS = 8;

    localparam int NUM_AXES = 3;

    // Configuration register map
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIME_STEP   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Z    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD_X    = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD_Y    = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PERIOD_Z    = 3'd7;

endpackage

@@ hw/rtl/trapezoid_position_advance_pbc_core.sv @@
// ============================================================================
// trapezoid_position_advance_pbc_core - trapezoidal position update with wrap
// Averages current and previous velocity, clamps speed, advances position by
// velocity times time step, folds it into a periodic box, and saturates.
// ============================================================================
// Usage:
//   Request channel: drive the nine input fields and pulse start. busy is
//   always low, so a request is taken on every cycle that start is high.
//   Result channel: done is high for one cycle with new_pos_x/y/z valid.
//   The receiver has no way to hold results; take them when done is high.
//   Configuration: write cfg_data to register cfg_index with cfg_we, only
//   while no request is in flight.
// Timing:
//   Fully pipelined, one request per cycle. The pipeline length is set by the
//   root unit and the speed-clamp divider (one bit per stage each), and the
//   wrap divider over the widened displacement.
// Reset:
//   rst_n clears the configuration registers and the valid chain; results in
//   flight are dropped. No clearing pass is needed afterwards.
// ============================================================================
module trapezoid_position_advance_pbc_core
    import tpa_pkg::*;
#(
    parameter int POS_WIDTH  = 40,
    parameter int STEP_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [((POS_WIDTH > STEP_WIDTH) ? POS_WIDTH : STEP_WIDTH)-1:0] cfg_data,
    input  logic signed [POS_WIDTH-1:0] old_pos_x,
    input  logic signed [POS_WIDTH-1:0] old_pos_y,
    input  logic signed [POS_WIDTH-1:0] old_pos_z,
    input  logic signed [POS_WIDTH-1:0] cur_vel_x,
    input  logic signed [POS_WIDTH-1:0] cur_vel_y,
    input  logic signed [POS_WIDTH-1:0] cur_vel_z,
    input  logic signed [POS_WIDTH-1:0] prev_vel_x,
    input  logic signed [POS_WIDTH-1:0] prev_vel_y,
    input  logic signed [POS_WIDTH-1:0] prev_vel_z,
    output logic signed [POS_WIDTH-1:0] new_pos_x,
    output logic signed [POS_WIDTH-1:0] new_pos_y,
    output logic signed [POS_WIDTH-1:0] new_pos_z
);

    localparam int W   = POS_WIDTH;
    localparam int S   = STEP_WIDTH;
    localparam int SF  = S - STEP_INT_BITS;
    localparam int DMW = W + STEP_INT_BITS;   // displacement magnitude
    localparam int XW  = DMW + 2;             // advanced position, signed
    localparam int TW  = XW + 1;              // offset from center, signed
    localparam int TMW = XW;                  // offset magnitude

    // Stage numbers, counted from the accepting edge as stage 1
    localparam int T_SS   = 4;
    localparam int T_DIV1 = T_SS + W;
    localparam int T_Q    = T_DIV1 + W - 1;
    localparam int T_R    = T_Q + 1;
    localparam int T_X    = T_R + 3;
    localparam int T_T    = T_X + 1;
    localparam int T_F    = T_T + TMW + 1;
    localparam int T_O    = T_F + 1;

    localparam logic [W+S-1:0] DISP_HALF = (W+S)'(1) << (SF - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [S-1:0]          time_step_reg;
    logic [W-2:0]          speed_limit_reg;
    logic signed [W-1:0]   center_reg [NUM_AXES];
    logic [W-2:0]          period_reg [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= '0;
            speed_limit_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                center_reg[i] <= '0;
                period_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_STEP:   time_step_reg   <= cfg_data[S-1:0];
                REG_SPEED_LIMIT: speed_limit_reg <= cfg_data[W-2:0];
                REG_CENTER_X:    center_reg[0]   <= cfg_data[W-1:0];
                REG_CENTER_Y:    center_reg[1]   <= cfg_data[W-1:0];
                REG_CENTER_Z:    center_reg[2]   <= cfg_data[W-1:0];
                REG_PERIOD_X:    period_reg[0]   <= cfg_data[W-2:0];
                REG_PERIOD_Y:    period_reg[1]   <= cfg_data[W-2:0];
                REG_PERIOD_Z:    period_reg[2]   <= cfg_data[W-2:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid chain: the pipeline never stalls
    // ------------------------------------------------------------------
    logic [T_O-1:0] vld_reg;
    logic [T_O-1:0] vld_next;

    assign vld_next = {vld_reg[T_O-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign busy = 1'b0;
    assign done = vld_reg[T_O-1];

    // ------------------------------------------------------------------
    // Input gathering
    // ------------------------------------------------------------------
    logic signed [W-1:0] in_pos  [NUM_AXES];
    logic signed [W-1:0] in_cur  [NUM_AXES];
    logic signed [W-1:0] in_prev [NUM_AXES];
    logic                prev_zero;

    assign in_pos[0]  = old_pos_x;
    assign in_pos[1]  = old_pos_y;
    assign in_pos[2]  = old_pos_z;
    assign in_cur[0]  = cur_vel_x;
    assign in_cur[1]  = cur_vel_y;
    assign in_cur[2]  = cur_vel_z;
    assign in_prev[0] = prev_vel_x;
    assign in_prev[1] = prev_vel_y;
    assign in_prev[2] = prev_vel_z;

    assign prev_zero = (prev_vel_x == '0) && (prev_vel_y == '0) && (prev_vel_z == '0);

    // Shared speed-check signals
    logic [2*W-1:0]   sq [NUM_AXES];
    logic [2*W-3:0]   slsq;
    logic [2*W+1:0]   ss_wide;
    logic [2*W-1:0]   ss_reg;
    logic [2*W-3:0]   slsq_reg;
    logic             over_reg;
    logic             over_next;
    logic             over_q;
    logic [W-1:0]     mag_root;

    logic signed [W-1:0] new_pos_reg [NUM_AXES];

    // ------------------------------------------------------------------
    // Per-axis datapath
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_axis
        logic signed [W-1:0] prv;
        logic [W:0]          vsum;
        logic [W:0]          vadj;
        logic [W:0]          vavg;
        logic [W:0]          vneg;
        logic                s1_sign_next;
        logic [W-1:0]        s1_mag_next;
        logic                s1_sign_reg;
        logic [W-1:0]        s1_mag_reg;
        logic [W-1:0]        s1_pos_reg;

        logic [2*W:0]        a1_out;
        logic [2*W:0]        b_out;
        logic [2*W-2:0]      vsl;
        logic [W-2:0]        quo1;
        logic [W-1:0]        rem1;
        logic [W-1:0]        dsr1;
        logic [W-1:0]        lr1;
        logic [W-1:0]        r_mag_next;
        logic [W-1:0]        r_mag_reg;
        logic                r_sign_reg;
        logic [W-1:0]        r_pos_reg;

        logic [W+S-1:0]      disp_prod;
        logic [W:0]          c_out;
        logic [W+S-1:0]      disp_rnd;
        logic [DMW-1:0]      disp_mag;
        logic [XW-1:0]       pos_ext;
        logic [XW-1:0]       x_next;
        logic [XW-1:0]       x_reg;

        logic [TW-1:0]       t_val;
        logic [TW-1:0]       t_neg;
        logic [TMW-1:0]      t_mag_next;
        logic [TMW-1:0]      t_mag_reg;
        logic                t_sign_reg;
        logic [XW-1:0]       tx_reg;

        logic [TMW-1:0]      quo2;
        logic [W-2:0]        rem2;
        logic [W-2:0]        dsr2;
        logic [XW:0]         d_out;
        logic [W-2:0]        lr2;
        logic                up;
        logic                fold_neg;
        logic [W-1:0]        fold_mag;
        logic [W-1:0]        f_res_next;
        logic [W-1:0]        f_res_reg;
        logic [XW-1:0]       f_x_reg;

        logic [XW-1:0]       o_sum;
        logic [XW-1:0]       o_val;
        logic                o_fits;
        logic [W-1:0]        o_next;

        // Average the two velocities, truncating toward zero
        always_comb
        begin
            prv          = prev_zero ? in_cur[g] : in_prev[g];
            vsum         = {in_cur[g][W-1], in_cur[g]} + {prv[W-1], prv};
            vadj         = vsum + {{W{1'b0}}, vsum[W]};
            vavg         = {vadj[W], vadj[W:1]};
            vneg         = '0 - vavg;
            s1_sign_next = vavg[W];
            s1_mag_next  = vavg[W] ? vneg[W-1:0] : vavg[W-1:0];
        end

        always_ff @(posedge clk)
        begin
            s1_sign_reg <= s1_sign_next;
            s1_mag_reg  <= s1_mag_next;
            s1_pos_reg  <= in_pos[g];
        end

        // Square of each component for the speed check
        tpa_mul #(.AW(W), .BW(W)) u_sq (
            .clk (clk),
            .a   (s1_mag_reg),
            .b   (s1_mag_reg),
            .p   (sq[g])
        );

        // Hold velocity and position while the root is formed
        tpa_delay #(.WIDTH(2*W+1), .DEPTH(W+1)) u_dly_a (
            .clk  (clk),
            .din  ({s1_sign_reg, s1_mag_reg, s1_pos_reg}),
            .dout (a1_out)
        );

        // Component times speed limit, ready with the root
        tpa_mul #(.AW(W), .BW(W-1)) u_vsl (
            .clk (clk),
            .a   (a1_out[2*W-1:W]),
            .b   (speed_limit_reg),
            .p   (vsl)
        );

        tpa_delay #(.WIDTH(2*W+1), .DEPTH(W+1)) u_dly_b (
            .clk  (clk),
            .din  (a1_out),
            .dout (b_out)
        );

        // Scale by limit over speed
        tpa_div #(.QB(W-1), .DW(W)) u_div_lim (
            .clk         (clk),
            .dividend    (vsl),
            .divisor     (mag_root),
            .quotient    (quo1),
            .remainder   (rem1),
            .divisor_out (dsr1)
        );

        // Round the scaled component half away from zero
        always_comb
        begin
            lr1        = dsr1 - rem1;
            r_mag_next = over_q ? (W'(quo1) + W'(rem1 >= lr1)) : b_out[2*W-1:W];
        end

        always_ff @(posedge clk)
        begin
            r_mag_reg  <= r_mag_next;
            r_sign_reg <= b_out[2*W];
            r_pos_reg  <= b_out[W-1:0];
        end

        // Velocity times time step
        tpa_mul #(.AW(W), .BW(S)) u_disp (
            .clk (clk),
            .a   (r_mag_reg),
            .b   (time_step_reg),
            .p   (disp_prod)
        );

        tpa_delay #(.WIDTH(W+1), .DEPTH(2)) u_dly_c (
            .clk  (clk),
            .din  ({r_sign_reg, r_pos_reg}),
            .dout (c_out)
        );

        // Round the displacement and advance the position
        always_comb
        begin
            disp_rnd = disp_prod + DISP_HALF;
            disp_mag = disp_rnd[W+S-1:SF];
            pos_ext  = {{(XW-W){c_out[W-1]}}, c_out[W-1:0]};
            x_next   = c_out[W] ? (pos_ext - {2'b00, disp_mag})
                                : (pos_ext + {2'b00, disp_mag});
        end

        always_ff @(posedge clk)
        begin
            x_reg <= x_next;
        end

        // Offset from the box center as sign and magnitude
        always_comb
        begin
            t_val      = {x_reg[XW-1], x_reg} - {{(TW-W){center_reg[g][W-1]}}, center_reg[g]};
            t_neg      = '0 - t_val;
            t_mag_next = t_val[TW-1] ? t_neg[TMW-1:0] : t_val[TMW-1:0];
        end

        always_ff @(posedge clk)
        begin
            t_mag_reg  <= t_mag_next;
            t_sign_reg <= t_val[TW-1];
            tx_reg     <= x_reg;
        end

        // Offset divided by box length
        tpa_div #(.QB(TMW), .DW(W-1)) u_div_wrap (
            .clk         (clk),
            .dividend    ({{(W-1){1'b0}}, t_mag_reg}),
            .divisor     (period_reg[g]),
            .quotient    (quo2),
            .remainder   (rem2),
            .divisor_out (dsr2)
        );

        tpa_delay #(.WIDTH(XW+1), .DEPTH(TMW)) u_dly_d (
            .clk  (clk),
            .din  ({t_sign_reg, tx_reg}),
            .dout (d_out)
        );

        // Fold the remainder to the nearest image, ties to even quotient
        always_comb
        begin
            lr2        = dsr2 - rem2;
            up         = (rem2 > lr2) || ((rem2 == lr2) && quo2[0]);
            fold_neg   = up ? !d_out[XW] : d_out[XW];
            fold_mag   = up ? W'(lr2) : W'(rem2);
            f_res_next = fold_neg ? ('0 - fold_mag) : fold_mag;
        end

        always_ff @(posedge clk)
        begin
            f_res_reg <= f_res_next;
            f_x_reg   <= d_out[XW-1:0];
        end

        // Re-center on periodic axes and saturate
        always_comb
        begin
            o_sum  = {{(XW-W){center_reg[g][W-1]}}, center_reg[g]}
                   + {{(XW-W){f_res_reg[W-1]}}, f_res_reg};
            o_val  = (period_reg[g] != '0) ? o_sum : f_x_reg;
            o_fits = (&o_val[XW-1:W-1]) || !(|o_val[XW-1:W-1]);
            if (o_fits)
            begin
                o_next = o_val[W-1:0];
            end
            else if (o_val[XW-1])
            begin
                o_next = {1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                o_next = {1'b0, {(W-1){1'b1}}};
            end
        end

        always_ff @(posedge clk)
        begin
            new_pos_reg[g] <= o_next;
        end
    end

    // ------------------------------------------------------------------
    // Speed check: sum of squares, compare, root
    // ------------------------------------------------------------------
    tpa_mul #(.AW(W-1), .BW(W-1)) u_slsq (
        .clk (clk),
        .a   (speed_limit_reg),
        .b   (speed_limit_reg),
        .p   (slsq)
    );

    assign ss_wide = (2*W+2)'(sq[0]) + (2*W+2)'(sq[1]) + (2*W+2)'(sq[2]);

    always_ff @(posedge clk)
    begin
        ss_reg   <= ss_wide[2*W-1:0];
        slsq_reg <= slsq;
    end

    assign over_next = (speed_limit_reg != '0) && (ss_reg > {2'b00, slsq_reg});

    always_ff @(posedge clk)
    begin
        over_reg <= over_next;
    end

    // Hold the clamp decision until the scaled values are ready
    tpa_delay #(.WIDTH(1), .DEPTH(2*W-2)) u_dly_over (
        .clk  (clk),
        .din  (over_reg),
        .dout (over_q)
    );

    tpa_sqrt #(.RB(W)) u_sqrt (
        .clk  (clk),
        .rad  (ss_reg),
        .root (mag_root)
    );

    assign new_pos_x = new_pos_reg[0];
    assign new_pos_y = new_pos_reg[1];
    assign new_pos_z = new_pos_reg[2];

endmodule

@@ hw/rtl/tpa_delay.sv @@
// ============================================================================
// tpa_delay - fixed-depth data delay line
// Carries side data alongside a pipelined unit, one register per cycle.
// ============================================================================
module tpa_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] stage_reg [DEPTH];

    // Shift the data one stage each cycle
    always_ff @(posedge clk)
    begin
        stage_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            stage_reg[i] <= stage_reg[i-1];
        end
    end

    assign dout = stage_reg[DEPTH-1];

endmodule

@@ hw/rtl/tpa_mul.sv @@
// ============================================================================
// tpa_mul - two-stage unsigned multiplier
// Splits operand b into two halves, forms both partial products in the first
// stage and adds them in the second.
// ============================================================================
module tpa_mul #(
    parameter int AW = 40,
    parameter int BW = 40
) (
    input  logic             clk,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] p
);

    localparam int BL = BW / 2;
    localparam int BH = BW - BL;

    logic [AW+BL-1:0] lo_reg;
    logic [AW+BH-1:0] hi_reg;
    logic [AW+BL-1:0] lo_next;
    logic [AW+BH-1:0] hi_next;
    logic [AW+BW-1:0] p_reg;
    logic [AW+BW-1:0] p_next;

    // Partial products on the low and high halves of b
    always_comb
    begin
        lo_next = (AW+BL)'(a) * (AW+BL)'(b[BL-1:0]);
        hi_next = (AW+BH)'(a) * (AW+BH)'(b[BW-1:BL]);
    end

    // Recombine the halves
    assign p_next = {hi_reg, {BL{1'b0}}} + (AW+BW)'(lo_reg);

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        p_reg  <= p_next;
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/tpa_sqrt.sv @@
// ============================================================================
// tpa_sqrt - pipelined integer square root
// Digit-by-digit restoring root, one root bit per register stage.
// ============================================================================
module tpa_sqrt #(
    parameter int RB = 40
) (
    input  logic            clk,
    input  logic [2*RB-1:0] rad,
    output logic [RB-1:0]   root
);

    localparam int RW = RB + 3;

    logic [RW-1:0]   rem_reg  [RB];
    logic [RB-1:0]   root_reg [RB];
    logic [2*RB-1:0] rad_reg  [RB];

    for (genvar g = 0; g < RB; g++)
    begin : g_stage
        logic [RW-1:0]   rem_in;
        logic [RB-1:0]   root_in;
        logic [2*RB-1:0] rad_in;
        logic [RW-1:0]   shifted;
        logic [RW-1:0]   trial;
        logic            fit;
        logic [RW-1:0]   rem_next;
        logic [RB-1:0]   root_next;
        logic [2*RB-1:0] rad_next;

        if (g == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rad_in  = rad_reg[g-1];
        end

        // Bring down two radicand bits, try root*4+1
        always_comb
        begin
            shifted   = {rem_in[RW-3:0], rad_in[2*RB-1 -: 2]};
            trial     = {1'b0, root_in, 2'b01};
            fit       = (shifted >= trial);
            rem_next  = fit ? (shifted - trial) : shifted;
            root_next = {root_in[RB-2:0], fit};
            rad_next  = {rad_in[2*RB-3:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= rem_next;
            root_reg[g] <= root_next;
            rad_reg[g]  <= rad_next;
        end
    end

    assign root = root_reg[RB-1];

endmodule

@@ hw/rtl/tpa_div.sv @@
// ============================================================================
// tpa_div - pipelined unsigned divider
// Restoring division, one quotient bit per register stage. The upper DW bits
// of the dividend must be below the divisor. The divisor travels along.
// ============================================================================
module tpa_div #(
    parameter int QB = 40,
    parameter int DW = 40
) (
    input  logic            clk,
    input  logic [QB+DW-1:0] dividend,
    input  logic [DW-1:0]   divisor,
    output logic [QB-1:0]   quotient,
    output logic [DW-1:0]   remainder,
    output logic [DW-1:0]   divisor_out
);

    logic [DW-1:0] rem_reg [QB];
    logic [QB-1:0] num_reg [QB];
    logic [QB-1:0] quo_reg [QB];
    logic [DW-1:0] dsr_reg [QB];

    for (genvar g = 0; g < QB; g++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QB-1:0] num_in;
        logic [QB-1:0] quo_in;
        logic [DW-1:0] dsr_in;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          fit;
        logic [DW-1:0] rem_next;
        logic [QB-1:0] num_next;
        logic [QB-1:0] quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = dividend[QB+DW-1:QB];
            assign num_in = dividend[QB-1:0];
            assign quo_in = '0;
            assign dsr_in = divisor;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign num_in = num_reg[g-1];
            assign quo_in = quo_reg[g-1];
            assign dsr_in = dsr_reg[g-1];
        end

        // Bring down one dividend bit and subtract when it fits
        always_comb
        begin
            sh       = {rem_in, num_in[QB-1]};
            diff     = sh - {1'b0, dsr_in};
            fit      = (sh >= {1'b0, dsr_in});
            rem_next = fit ? diff[DW-1:0] : sh[DW-1:0];
            num_next = {num_in[QB-2:0], 1'b0};
            quo_next = {quo_in[QB-2:0], fit};
        end

        always_ff @(posedge clk)
        begin
            rem_reg[g] <= rem_next;
            num_reg[g] <= num_next;
            quo_reg[g] <= quo_next;
            dsr_reg[g] <= dsr_in;
        end
    end

    assign quotient    = quo_reg[QB-1];
    assign remainder   = rem_reg[QB-1];
    assign divisor_out = dsr_reg[QB-1];

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top - testbench for the trapezoid position advance core
// Drives node requests with random gaps, predicts each new position from the
// current register settings, and checks every done strobe in order. A short
// directed table runs first, then random blocks under changing settings.
// ----------------------------------------------------------------------------
module tb_top
    import tpa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW   = 40;
    localparam int SW   = 32;
    localparam int NRND = 1250;

    typedef logic [2:0][PW-1:0] trio_t;
    typedef logic signed [129:0] wide_t;

    typedef struct {
        int    phase;
        trio_t old_pos;
        trio_t cur_vel;
        trio_t prev_vel;
        bit    typed;
        trio_t want;
    } vec_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic          done;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [PW-1:0] cfg_data;
    trio_t         old_pos, cur_vel, prev_vel;
    logic signed [PW-1:0] new_pos_x, new_pos_y, new_pos_z;

    // shadow copy of the register file
    logic [SW-1:0]   step_r;
    logic [PW-2:0]   limit_r;
    logic [PW-1:0]   center_r [3];
    logic [PW-2:0]   period_r [3];

    trio_t pos_q [$];
    vec_t  vec_q [$];
    int    n_err;
    int    n_req;
    int    n_res;

    trapezoid_position_advance_pbc_core #(.POS_WIDTH(PW), .STEP_WIDTH(SW)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .old_pos_x(old_pos[0]), .old_pos_y(old_pos[1]), .old_pos_z(old_pos[2]),
        .cur_vel_x(cur_vel[0]), .cur_vel_y(cur_vel[1]), .cur_vel_z(cur_vel[2]),
        .prev_vel_x(prev_vel[0]), .prev_vel_y(prev_vel[1]), .prev_vel_z(prev_vel[2]),
        .new_pos_x(new_pos_x), .new_pos_y(new_pos_y), .new_pos_z(new_pos_z)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    // floor square root of a 128-bit value
    function automatic logic [127:0] isqrt(input logic [127:0] n);
        logic [127:0] root;
        logic [127:0] c;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = root | (128'd1 << b);
            if (c * c <= n)
                root = c;
        end
        return root;
    endfunction

    // average velocity, clamp speed, advance, fold into box, saturate
    function automatic trio_t advance_pos(input trio_t op, input trio_t cv, input trio_t pv);
        logic [127:0] mv [3];
        logic         negv [3];
        logic [127:0] ss, lim, mag, q, r, dm, tm, len;
        wide_t        a, b, x, d, t, res;
        logic         pz, tn, up;
        trio_t        out;
        pz = (pv == '0);
        for (int i = 0; i < 3; i++)
        begin
            a = $signed(cv[i]);
            b = pz ? a : wide_t'($signed(pv[i]));
            a = (a + b) / 2;
            negv[i] = a < 0;
            b = negv[i] ? -a : a;
            mv[i] = b[127:0];
        end
        lim = limit_r;
        if (lim != 0)
        begin
            ss = mv[0] * mv[0] + mv[1] * mv[1] + mv[2] * mv[2];
            if (ss > lim * lim)
            begin
                mag = isqrt(ss);
                for (int i = 0; i < 3; i++)
                begin
                    q = (mv[i] * lim) / mag;
                    r = (mv[i] * lim) % mag;
                    if (r >= mag - r)
                        q = q + 1;
                    mv[i] = q;
                    if (q == 0)
                        negv[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            dm = (mv[i] * 128'(step_r) + (128'd1 << 23)) >> 24;
            d = wide_t'(dm);
            if (negv[i])
                d = -d;
            x = wide_t'($signed(op[i])) + d;
            if (period_r[i] != 0)
            begin
                len = period_r[i];
                t = x - wide_t'($signed(center_r[i]));
                tn = t < 0;
                a = tn ? -t : t;
                tm = a[127:0];
                q = tm / len;
                r = tm % len;
                up = (r > len - r) || (r == len - r && q[0]);
                res = up ? wide_t'(len - r) : wide_t'(r);
                if (up ^ tn)
                    res = -res;
                x = wide_t'($signed(center_r[i])) + res;
            end
            if (x > wide_t'(40'sh7F_FFFF_FFFF))
                out[i] = 40'h7F_FFFF_FFFF;
            else if (x < -(wide_t'(1) <<< 39))
                out[i] = 40'h80_0000_0000;
            else
                out[i] = x[PW-1:0];
        end
        return out;
    endfunction

    // write one register, call at a rising edge; the caller drops cfg_we after the last
    task automatic write_reg(input logic [2:0] idx, input logic [PW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_TIME_STEP:   step_r = val[SW-1:0];
            REG_SPEED_LIMIT: limit_r = val[PW-2:0];
            REG_CENTER_X:    center_r[0] = val;
            REG_CENTER_Y:    center_r[1] = val;
            REG_CENTER_Z:    center_r[2] = val;
            REG_PERIOD_X:    period_r[0] = val[PW-2:0];
            REG_PERIOD_Y:    period_r[1] = val[PW-2:0];
            REG_PERIOD_Z:    period_r[2] = val[PW-2:0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    // hold until every pending result has come back
    task automatic drain();
        while (pos_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // send one request and queue its expected position
    task automatic send_node(input trio_t op, input trio_t cv, input trio_t pv,
                             input bit typed, input trio_t want);
        start    <= 1'b1;
        old_pos  <= op;
        cur_vel  <= cv;
        prev_vel <= pv;
        do
            @(posedge clk);
        while (busy);
        pos_q.push_back(typed ? want : advance_pos(op, cv, pv));
        n_req++;
    endtask

    task automatic idle_gap(input bit burst);
        int g;
        int r;
        r = $urandom_range(0, 99);
        g = burst ? 0 : (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [PW-1:0] rand_field();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0, 1: return w[PW-1:0];
            2: return PW'($signed(w[23:0]));
            3: return PW'($signed(w[33:0]));
            default:
                case ($urandom_range(0, 3))
                    0: return 40'h7F_FFFF_FFFF;
                    1: return 40'h80_0000_0000;
                    2: return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    function automatic logic [PW-1:0] rand_span(input int k);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return '0;
            1: return PW'($urandom_range(1, 1 << 24));
            2: return (k % 3 == 0) ? {1'b0, {(PW-1){1'b1}}} : PW'($urandom_range(1 << 16, 1 << 30));
            default: return w[PW-1:0];
        endcase
    endfunction

    // pick a register setting for one random block
    task automatic apply_setting(input int k);
        logic [63:0] w;
        w = {$urandom, $urandom};
        case (k)
            0: write_reg(REG_TIME_STEP, '1);
            1: write_reg(REG_TIME_STEP, '0);
            default: write_reg(REG_TIME_STEP,
                ($urandom_range(0, 1) != 0) ? PW'($urandom_range(0, 1 << 26)) : w[PW-1:0]);
        endcase
        write_reg(REG_SPEED_LIMIT, (k == 2) ? '1 : rand_span(k));
        write_reg(REG_CENTER_X, (k == 2) ? 40'h80_0000_0000 : rand_field());
        write_reg(REG_CENTER_Y, (k == 2) ? 40'h7F_FFFF_FFFF : rand_field());
        write_reg(REG_CENTER_Z, rand_field());
        write_reg(REG_PERIOD_X, (k == 2) ? '1 : rand_span(k));
        write_reg(REG_PERIOD_Y, (k == 2) ? '1 : rand_span(k));
        write_reg(REG_PERIOD_Z, (k == 1) ? '0 : rand_span(k));
        cfg_we <= 1'b0;
    endtask

    function automatic trio_t tri3(input logic [PW-1:0] a, b, c);
        return {c, b, a};
    endfunction

    task automatic add_vec(input int ph, input trio_t op, input trio_t cv, input trio_t pv,
                           input bit typed, input trio_t want);
        vec_t v;
        v.phase = ph; v.old_pos = op; v.cur_vel = cv; v.prev_vel = pv;
        v.typed = typed; v.want = want;
        vec_q.push_back(v);
    endtask

    // settings for each directed phase, in register index order
    task automatic apply_phase(input int ph);
        logic [PW-1:0] s [8];
        case (ph)
            1: s = '{40'hFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0};
            2: s = '{40'h00_0100_0000, 40'h3_0000, 0, 0, -40'sh1_0000,
                     40'hA_0000, 0, 40'h7_0000};
            default: s = '{40'h00_0000_0001, 40'hFF_FFFF_FFFF, 40'h80_0000_0000,
                           40'h7F_FFFF_FFFF, 0, 40'hFF_FFFF_FFFF, 40'h7F_FFFF_FFFF,
                           40'h2_0000};
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), s[i]);
        cfg_we <= 1'b0;
    endtask

    // compare one field of a result
    function automatic void check_field(input string name, input logic [PW-1:0] want,
                                        input logic [PW-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d actual %0d", name, $signed(want), $signed(got));
            n_err++;
        end
    endfunction

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pos_q.size() == 0)
            begin
                $error("result with no request pending");
                n_err++;
            end
            else
            begin
                check_field("new_pos_x", pos_q[0][0], new_pos_x);
                check_field("new_pos_y", pos_q[0][1], new_pos_y);
                check_field("new_pos_z", pos_q[0][2], new_pos_z);
                void'(pos_q.pop_front());
                n_res++;
            end
        end
    end

    localparam logic [PW-1:0] PMAX = 40'h7F_FFFF_FFFF;
    localparam logic [PW-1:0] PMIN = 40'h80_0000_0000;
    localparam logic [PW-1:0] ONE  = 40'h1_0000;

    initial
    begin
        int ph;
        int wait_cnt;
        bit burst;
        rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        old_pos = '0; cur_vel = '0; prev_vel = '0;
        step_r = '0; limit_r = '0;
        for (int i = 0; i < 3; i++)
        begin
            center_r[i] = '0;
            period_r[i] = '0;
        end
        n_err = 0; n_req = 0; n_res = 0;

        // zero time step after reset: position passes through unchanged
        add_vec(0, tri3(PMAX, PMIN, 0), tri3(PMAX, PMAX, PMIN), tri3(PMIN, 0, 1), 1,
                tri3(PMAX, PMIN, 0));
        add_vec(0, tri3(PMIN, '1, ONE), tri3('1, PMIN, 0), tri3(0, 0, 0), 1,
                tri3(PMIN, '1, ONE));
        // huge step: saturation and exact wide displacement
        add_vec(1, tri3(PMAX, PMIN, 0), tri3(PMAX, PMIN, 1), tri3(0, 0, 0), 0, '0);
        add_vec(1, tri3(PMIN, PMAX, '1), tri3(PMIN, PMAX, '1), tri3(PMAX, PMIN, 1), 0, '0);
        add_vec(1, tri3(0, 0, 0), tri3(3, -40'sd3, 1), tri3(-40'sd2, 2, 0), 0, '0);
        // unit step: speed clamp, box fold with half-way ties
        add_vec(2, tri3(0, 0, 0), tri3(3 * ONE, 4 * ONE, 0), tri3(0, 0, 0), 0, '0);
        add_vec(2, tri3(5 * ONE, 0, 40'h2_8000), tri3(0, 0, 0), tri3(0, 0, 0), 0, '0);
        add_vec(2, tri3(15 * ONE, 0, 40'h3_8000), tri3(0, 0, 0), tri3(0, 0, 0), 0, '0);
        add_vec(2, tri3(-40'sd5 * ONE, 0, 0), tri3(ONE, ONE, ONE), tri3(-ONE, ONE, 2*ONE), 0, '0);
        add_vec(2, tri3(0, 0, 0), tri3(PMAX, PMIN, PMAX), tri3(PMIN, PMIN, 1), 0, '0);
        add_vec(2, tri3(ONE, 0, 0), tri3(1, 0, 0), tri3(2, 0, 0), 0, '0);
        // extreme box and limit settings
        add_vec(3, tri3(PMAX, PMIN, PMAX), tri3(PMAX, PMIN, '1), tri3(0, 0, 0), 0, '0);
        add_vec(3, tri3(PMIN, PMAX, PMIN), tri3(PMIN, PMAX, 1), tri3(1, 1, 1), 0, '0);
        add_vec(3, tri3(0, '1, 40'h1_0000), tri3(40'hFF_FFFF, 0, 40'h80_0000), tri3(0, 0, 0),
                0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table, applying settings at each phase change
        ph = 0;
        foreach (vec_q[i])
        begin
            if (vec_q[i].phase != ph)
            begin
                start <= 1'b0;
                drain();
                ph = vec_q[i].phase;
                apply_phase(ph);
            end
            send_node(vec_q[i].old_pos, vec_q[i].cur_vel, vec_q[i].prev_vel,
                      vec_q[i].typed, vec_q[i].want);
            idle_gap(1'b0);
        end

        // random blocks, each under its own setting
        for (int k = 0; k < 10; k++)
        begin
            start <= 1'b0;
            drain();
            apply_setting(k);
            burst = ($urandom_range(0, 2) == 0);
            for (int j = 0; j < NRND / 10; j++)
            begin
                trio_t op, cv, pv;
                for (int a = 0; a < 3; a++)
                begin
                    op[a] = rand_field();
                    cv[a] = rand_field();
                    pv[a] = rand_field();
                end
                if ($urandom_range(0, 4) == 0)
                    pv = '0;
                send_node(op, cv, pv, 1'b0, '0);
                idle_gap(burst);
            end
        end
        start <= 1'b0;

        // wait out the pipeline
        wait_cnt = 0;
        while (pos_q.size() != 0 && wait_cnt < 2000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        if (pos_q.size() != 0)
        begin
            $error("%0d results never arrived", pos_q.size());
            n_err++;
        end
        repeat (150) @(posedge clk);

        $display("Covered %0d requests and %0d results over 4 directed and 10 random settings.",
                 n_req, n_res);
        $display("Errors: %0d", n_err);
        if (n_err == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tpa_pkg.sv
hw/rtl/tpa_delay.sv
hw/rtl/tpa_mul.sv
hw/rtl/tpa_sqrt.sv
hw/rtl/tpa_div.sv
hw/rtl/trapezoid_position_advance_pbc_core.sv
tb/sv/tb_top.sv
